FILE: rtl/lgw_pkg.sv
// ----------------------------------------------------------------------------
// lgw_pkg
// Shared types and constants for the gradient wave color block: register
// indexes, item kinds, divider control and segment lookup results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lgw_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_A = 3'd4;

  // Item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_KEY  = 1'b1;

  // Key positions are normalized to this full scale
  localparam logic [10:0] POS_FULL = 11'd1024;

  // Fraction bits of the phase accumulator (Q.10 times Q4.12)
  localparam int FRAC_W = 22;

  // Divider step counter and step counts per operation
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] NB_MOD  = 5'd17;
  localparam logic [CNT_W-1:0] NB_CHAN = 5'd8;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] nbits;
  } div_ctl_t;

  // Segment lookup: current color slot and the one it blends into
  typedef struct packed {
    logic [1:0] idx;
    logic [1:0] nxt;
  } seg_t;

endpackage

`default_nettype wire

FILE: rtl/lgw_div.sv
// ----------------------------------------------------------------------------
// lgw_div
// Shared restoring divider, one quotient bit per cycle. The caller gives the
// number of quotient bits; the upper dividend bits must already be below the
// divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgw_div #(
  parameter int NW = 26
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lgw_pkg::div_ctl_t     ctl,
  input  logic [NW-1:0]         dividend,
  input  logic [15:0]           divisor,
  output logic                  done,
  output logic [NW-1:0]         quot,
  output logic [15:0]           rem
);
  import lgw_pkg::*;

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [NW-1:0]        acc;
  logic [15:0]          rem_q;
  logic [15:0]          dvs;
  logic [17:0]          trial;
  logic                 take;
  logic [CNT_W-1:0]     lshift;
  logic [NW-1:0]        acc_init;
  logic [NW-1:0]        rem_init;

  // Trial subtract of the shifted partial remainder
  assign trial = {1'b0, rem_q, acc[NW-1]} - {2'b00, dvs};
  assign take  = ~trial[17];

  // Align the low dividend bits to the top, upper bits form the remainder
  assign lshift   = CNT_W'(NW) - ctl.nbits;
  assign acc_init = dividend << lshift;
  assign rem_init = dividend >> ctl.nbits;

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.nbits;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc   <= acc_init;
      rem_q <= rem_init[15:0];
      dvs   <= divisor;
    end else if (busy) begin
      acc   <= {acc[NW-2:0], take};
      rem_q <= take ? trial[15:0] : {rem_q[14:0], acc[NW-1]};
    end
  end

  assign quot = acc;
  assign rem  = rem_q;

endmodule

`default_nettype wire

FILE: rtl/lgw_seg.sv
// ----------------------------------------------------------------------------
// lgw_seg
// Gradient segment lookup: finds which color segment a wave position falls
// in, its length and the offset of the position inside it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgw_seg #(
  parameter int PHASE_STEPS = 1024
) (
  input  logic [$clog2(PHASE_STEPS)-1:0] pos,
  input  logic [2:0]                     ncol,
  output lgw_pkg::seg_t                  seg,
  output logic [$clog2(PHASE_STEPS):0]   len,
  output logic [$clog2(PHASE_STEPS):0]   off
);
  import lgw_pkg::*;

  localparam int PW = $clog2(PHASE_STEPS);

  localparam logic [PW:0] B_FULL    = (PW+1)'(PHASE_STEPS);
  localparam logic [PW:0] B_HALF    = (PW+1)'(PHASE_STEPS / 2);
  localparam logic [PW:0] B_THIRD   = (PW+1)'(PHASE_STEPS / 3);
  localparam logic [PW:0] B_2THIRD  = (PW+1)'(2 * PHASE_STEPS / 3);
  localparam logic [PW:0] B_QUARTER = (PW+1)'(PHASE_STEPS / 4);
  localparam logic [PW:0] B_3QUART  = (PW+1)'(3 * PHASE_STEPS / 4);

  logic [PW:0] b1, b2, b3;
  logic [PW:0] pos_e;
  logic [PW:0] first, last;
  logic [1:0]  r;
  logic [2:0]  r_inc;

  assign pos_e = {1'b0, pos};

  // Segment bounds for the active color count
  always_comb begin
    case (ncol)
      3'd1: begin
        b1 = B_FULL;
        b2 = B_FULL;
        b3 = B_FULL;
      end
      3'd2: begin
        b1 = B_HALF;
        b2 = B_FULL;
        b3 = B_FULL;
      end
      3'd3: begin
        b1 = B_THIRD;
        b2 = B_2THIRD;
        b3 = B_FULL;
      end
      default: begin
        b1 = B_QUARTER;
        b2 = B_HALF;
        b3 = B_3QUART;
      end
    endcase
  end

  // Locate the segment
  always_comb begin
    if (pos_e < b1) begin
      r     = 2'd0;
      first = '0;
      last  = b1;
    end else if (pos_e < b2) begin
      r     = 2'd1;
      first = b1;
      last  = b2;
    end else if (pos_e < b3) begin
      r     = 2'd2;
      first = b2;
      last  = b3;
    end else begin
      r     = 2'd3;
      first = b3;
      last  = B_FULL;
    end
  end

  // Last segment blends back into the first color
  assign r_inc   = {1'b0, r} + 3'd1;
  assign seg.idx = r;
  assign seg.nxt = (r_inc >= ncol) ? 2'd0 : r_inc[1:0];
  assign len     = last - first;
  assign off     = pos_e - first;

endmodule

`default_nettype wire

FILE: rtl/led_gradient_wave_color.sv
// ----------------------------------------------------------------------------
// led_gradient_wave_color
// Gradient wave color generator. Tick transactions advance a cycle timer and
// latch the wave step; key transactions return the key color interpolated
// around the configured color loop at the key's wave position.
// ----------------------------------------------------------------------------
// Tick: no result; a zero period clears timer and wave step, else the shared
//   divider computes the timer modulo and then the wave step.
// Key: with no colors the result is zero, else the divider computes each of
//   the four color channels in turn. One transaction at a time.
// Reset: synchronous, clears timer, wave step, handshake state and all
//   configuration registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module led_gradient_wave_color #(
  parameter int PHASE_STEPS = 1024,
  parameter int MAX_COLORS  = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             kind,
  input  logic [15:0]                      elapsed_ms,
  input  logic [10:0]                      key_x,
  input  logic [10:0]                      key_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [31:0]                      color,
  input  logic                             cfg_we,
  input  logic [lgw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lgw_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lgw_pkg::*;

  localparam int PW = $clog2(PHASE_STEPS);
  localparam int NW = 16 + PW;
  localparam logic [PW:0] PS_C = (PW+1)'(PHASE_STEPS);

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MOD    = 4'd1;
  localparam logic [3:0] S_WSTART = 4'd2;
  localparam logic [3:0] S_WAVE   = 4'd3;
  localparam logic [3:0] S_MUL1   = 4'd4;
  localparam logic [3:0] S_MUL2   = 4'd5;
  localparam logic [3:0] S_PHASE  = 4'd6;
  localparam logic [3:0] S_POS    = 4'd7;
  localparam logic [3:0] S_SEG    = 4'd8;
  localparam logic [3:0] S_CDIV   = 4'd9;
  localparam logic [3:0] S_CWAIT  = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  // Configuration registers
  logic [15:0]        period_ms;
  logic signed [15:0] freq_x;
  logic signed [15:0] freq_y;
  logic [2:0]         color_count;
  logic [31:0]        colors [MAX_COLORS];

  // Wave state
  logic [15:0]        cycle_time;
  logic [PW-1:0]      wave_step;

  // Sequencer and datapath registers
  logic [3:0]         state;
  logic [10:0]        kx_q;
  logic [10:0]        kyi_q;
  logic signed [27:0] acc;
  logic [PW-1:0]      ph_q;
  logic [PW-1:0]      pos_q;
  logic [PW:0]        len_q;
  logic [PW:0]        off_q;
  logic [31:0]        ca_q;
  logic [31:0]        cb_q;
  logic [31:0]        res;
  logic [1:0]         chan;

  // Combinational helpers
  logic [2:0]          ncol;
  logic [10:0]         x_sat;
  logic [10:0]         y_sat;
  logic [10:0]         y_inv;
  logic signed [15:0]  mul_a;
  logic signed [11:0]  mul_bs;
  logic signed [27:0]  mul_p;
  logic [FRAC_W+PW:0]  ph_prod;
  logic [PW:0]         pos_sum;
  seg_t                seg;
  logic [PW:0]         seg_len;
  logic [PW:0]         seg_off;
  logic [31:0]         a_sel;
  logic [31:0]         b_sel;
  logic [7:0]          ch_a;
  logic [7:0]          ch_b;
  logic [PW+8:0]       numer;
  logic [16:0]         sum17;
  logic [16+PW:0]      ct_prod;
  logic                accept;
  logic                out_load;

  // Divider interface
  div_ctl_t            div_ctl;
  logic [NW-1:0]       div_dividend;
  logic [15:0]         div_divisor;
  logic                div_done;
  logic [NW-1:0]       div_quot;
  logic [15:0]         div_rem;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign out_load = (state == S_OUT) & (~out_valid | out_ready);

  assign ncol = (color_count > 3'(MAX_COLORS)) ? 3'(MAX_COLORS) : color_count;

  // Key position normalization
  assign x_sat = (key_x > POS_FULL) ? POS_FULL : key_x;
  assign y_sat = (key_y > POS_FULL) ? POS_FULL : key_y;
  assign y_inv = POS_FULL - y_sat;

  // Shared multiplier for the two phase terms
  assign mul_a  = (state == S_MUL1) ? freq_x : freq_y;
  assign mul_bs = {1'b0, (state == S_MUL1) ? kx_q : kyi_q};
  assign mul_p  = mul_a * mul_bs;

  // Phase fraction scaled to wave steps
  assign ph_prod = {{(PW+1){1'b0}}, acc[FRAC_W-1:0]} * {{FRAC_W{1'b0}}, PS_C};

  // Wave position, wrapped into one period of steps
  assign pos_sum = {1'b0, wave_step} + ((wave_step < ph_q) ? PS_C : '0) - {1'b0, ph_q};

  lgw_seg #(
    .PHASE_STEPS (PHASE_STEPS)
  ) u_seg (
    .pos  (pos_q),
    .ncol (ncol),
    .seg  (seg),
    .len  (seg_len),
    .off  (seg_off)
  );

  // Color slot select
  always_comb begin
    a_sel = '0;
    b_sel = '0;
    for (int i = 0; i < MAX_COLORS; i++) begin
      if (seg.idx == 2'(i)) a_sel = colors[i];
      if (seg.nxt == 2'(i)) b_sel = colors[i];
    end
  end

  // Blend numerator for the current channel
  assign ch_a  = ca_q[{chan, 3'b000} +: 8];
  assign ch_b  = cb_q[{chan, 3'b000} +: 8];
  assign numer = ({{(PW+1){1'b0}}, ch_a} * (len_q - off_q))
               + ({{(PW+1){1'b0}}, ch_b} * off_q);

  assign sum17   = {1'b0, cycle_time} + {1'b0, elapsed_ms};
  assign ct_prod = {{(PW+1){1'b0}}, cycle_time} * {16'd0, PS_C};

  // Divider operand select
  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.nbits = NB_MOD;
    div_dividend  = {{(NW-17){1'b0}}, sum17};
    div_divisor   = period_ms;
    case (state)
      S_IDLE: begin
        div_ctl.start = accept & (kind == KIND_TICK) & (period_ms != 16'd0);
      end
      S_WSTART: begin
        div_ctl.start = 1'b1;
        div_ctl.nbits = CNT_W'(PW);
        div_dividend  = ct_prod[NW-1:0];
      end
      S_CDIV: begin
        div_ctl.start = 1'b1;
        div_ctl.nbits = NB_CHAN;
        div_dividend  = {{(NW-PW-9){1'b0}}, numer};
        div_divisor   = {{(15-PW){1'b0}}, len_q};
      end
      default: begin
      end
    endcase
  end

  lgw_div #(
    .NW (NW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      period_ms   <= 16'd10000;
      freq_x      <= 16'sd0;
      freq_y      <= 16'sd4096;
      color_count <= 3'd0;
      for (int i = 0; i < MAX_COLORS; i++) colors[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PERIOD: period_ms   <= cfg_data[15:0];
        CFG_FREQ_X: freq_x      <= cfg_data[15:0];
        CFG_FREQ_Y: freq_y      <= cfg_data[15:0];
        CFG_COUNT:  color_count <= cfg_data[2:0];
        default: begin
        end
      endcase
      for (int i = 0; i < MAX_COLORS; i++) begin
        if (cfg_index == CFG_IDX_W'(int'(CFG_COLOR_A) + i)) colors[i] <= cfg_data;
      end
    end
  end

  // Sequencer, wave state and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cycle_time <= '0;
      wave_step  <= '0;
      chan       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (kind == KIND_KEY) begin
              state <= S_MUL1;
            end else if (period_ms != 16'd0) begin
              state <= S_MOD;
            end else begin
              cycle_time <= '0;
              wave_step  <= '0;
            end
          end
        end
        S_MOD: begin
          if (div_done) begin
            cycle_time <= div_rem;
            state      <= S_WSTART;
          end
        end
        S_WSTART: state <= S_WAVE;
        S_WAVE: begin
          if (div_done) begin
            wave_step <= div_quot[PW-1:0];
            state     <= S_IDLE;
          end
        end
        S_MUL1:  state <= S_MUL2;
        S_MUL2:  state <= S_PHASE;
        S_PHASE: state <= (ncol == 3'd0) ? S_OUT : S_POS;
        S_POS:   state <= S_SEG;
        S_SEG: begin
          chan  <= '0;
          state <= S_CDIV;
        end
        S_CDIV:  state <= S_CWAIT;
        S_CWAIT: begin
          if (div_done) begin
            chan  <= chan + 2'd1;
            state <= (chan == 2'd3) ? S_OUT : S_CDIV;
          end
        end
        S_OUT: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        kx_q  <= x_sat;
        kyi_q <= y_inv;
      end
      S_MUL1: acc <= mul_p;
      S_MUL2: acc <= acc + mul_p;
      S_PHASE: begin
        ph_q <= ph_prod[FRAC_W+PW-1:FRAC_W];
        res  <= '0;
      end
      S_POS: pos_q <= pos_sum[PW-1:0];
      S_SEG: begin
        ca_q  <= a_sel;
        cb_q  <= b_sel;
        len_q <= seg_len;
        off_q <= seg_off;
      end
      S_CWAIT: begin
        if (div_done) res[{chan, 3'b000} +: 8] <= div_quot[7:0];
      end
      default: begin
      end
    endcase
    if (out_load) color <= res;
  end

  // Divider results only arrive while the sequencer waits for them
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_MOD || state == S_WAVE || state == S_CWAIT))
    else $error("divider done outside a wait state");

  // Timer is reduced below the period before the wave step division
  a_cycle_time_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WSTART) |-> (cycle_time < period_ms))
    else $error("cycle time not below period");

  // Wave position stays inside one period of steps
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEG) |-> ({1'b0, pos_q} < PS_C))
    else $error("wave position out of range");

endmodule

`default_nettype wire

FILE: tb/gradient_color_checker.sv
// ----------------------------------------------------------------------------
// gradient_color_checker
// Watches the item, result and register ports of the gradient wave color
// block, tracks the wave timer and register state, predicts the key color
// of every accepted key transaction and compares the returned colors in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gradient_color_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           kind,
  input  logic [15:0]                    elapsed_ms,
  input  logic [10:0]                    key_x,
  input  logic [10:0]                    key_y,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [31:0]                    color,
  input  logic                           cfg_we,
  input  logic [lgw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lgw_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import lgw_pkg::*;

  localparam int STEPS      = 1024;
  localparam int COLOR_MAX  = 4;
  localparam int REPORT_MAX = 10;

  // Shadow registers and wave state
  logic [15:0]        period_ms;
  logic signed [15:0] freq_x;
  logic signed [15:0] freq_y;
  logic [2:0]         color_count;
  logic [31:0]        palette [4];
  logic [15:0]        cycle_time;
  logic [9:0]         wave_step;

  // Key colors still owed by the block, oldest first
  logic [31:0] expected_colors [$];

  // Phase of a key: fraction of fx*x + fy*(1-y) in Q.22, top 10 bits
  function automatic logic [9:0] key_phase(input logic [10:0] kx, input logic [10:0] ky);
    logic signed [63:0] xs, ys, fx, fy, acc;
    xs = 0;
    ys = 0;
    xs[10:0] = (kx > POS_FULL) ? POS_FULL : kx;
    ys[10:0] = (ky > POS_FULL) ? POS_FULL : ky;
    fx = freq_x;
    fy = freq_y;
    acc = fx * xs + fy * (STEPS - ys);
    return acc[21:12];
  endfunction

  // Linear blend around the closed color loop
  function automatic logic [31:0] loop_color(input logic [9:0] pos);
    int n, r, seg, first, last, len, off, ca, cb, v;
    logic [31:0] a, b, mix;
    n = (color_count > COLOR_MAX) ? COLOR_MAX : color_count;
    if (n == 0) return 32'h0;
    // smallest segment whose end lies above the position
    seg = n - 1;
    for (r = n - 1; r >= 0; r--) begin
      if (pos < (r + 1) * STEPS / n) seg = r;
    end
    first = seg * STEPS / n;
    last  = (seg + 1) * STEPS / n;
    len   = last - first;
    off   = pos - first;
    a = palette[seg];
    b = palette[(seg + 1 >= n) ? 0 : seg + 1];
    mix = 32'h0;
    for (r = 0; r < 4; r++) begin
      ca = a[8*r +: 8];
      cb = b[8*r +: 8];
      v  = (ca * (len - off) + cb * off) / len;
      mix[8*r +: 8] = v[7:0];
    end
    return mix;
  endfunction

  task automatic note_failure(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    if (fail_count < REPORT_MAX)
      $display("%0t: %s: expected %08h, got %08h", $realtime, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin : track
    logic [31:0] want;
    logic [16:0] sum;
    logic [31:0] scaled;
    if (rst) begin
      period_ms   = 16'd10000;
      freq_x      = 16'sd0;
      freq_y      = 16'sd4096;
      color_count = 3'd0;
      for (int k = 0; k < 4; k++) palette[k] = 32'h0;
      cycle_time  = 16'd0;
      wave_step   = 10'd0;
      expected_colors.delete();
      fail_count  = 0;
    end else begin
      // result side: compare against the oldest owed color
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          note_failure("unexpected color transaction", 32'h0, color);
        end else begin
          want = expected_colors.pop_front();
          if (color !== want) note_failure("color mismatch", want, color);
        end
      end

      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_PERIOD: period_ms   = cfg_data[15:0];
          CFG_FREQ_X: freq_x      = cfg_data[15:0];
          CFG_FREQ_Y: freq_y      = cfg_data[15:0];
          CFG_COUNT:  color_count = cfg_data[2:0];
          default:    palette[2'(cfg_index - CFG_COLOR_A)] = cfg_data;
        endcase
      end

      // item side
      if (in_valid && in_ready) begin
        if (kind == KIND_TICK) begin
          if (period_ms == 16'd0) begin
            cycle_time = 16'd0;
            wave_step  = 10'd0;
          end else begin
            sum        = {1'b0, cycle_time} + {1'b0, elapsed_ms};
            cycle_time = 16'(sum % period_ms);
            scaled     = {6'd0, cycle_time, 10'd0};
            wave_step  = 10'(scaled / period_ms);
          end
        end else begin
          expected_colors.push_back(loop_color(wave_step - key_phase(key_x, key_y)));
        end
      end
    end
    pending = expected_colors.size();
  end

endmodule

FILE: tb/led_gradient_wave_color_test.sv
// ----------------------------------------------------------------------------
// led_gradient_wave_color_test
// Drives tick and key transactions into the gradient wave color block under
// a series of register settings, with random idle bursts on both channels
// and one long output hold-off; the checker beside the block scores colors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_gradient_wave_color_test;
  import lgw_pkg::*;

  localparam int RUN_LIMIT     = 500000;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 110;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  kind;
  logic [15:0]           elapsed_ms;
  logic [10:0]           key_x;
  logic [10:0]           key_y;
  logic                  out_valid;
  logic                  out_ready;
  logic [31:0]           color;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  bit calm;       // no idling on either side
  bit long_hold;  // request for one long output hold-off

  led_gradient_wave_color dut (.*);
  gradient_color_checker check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  initial begin : watchdog
    repeat (RUN_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // Result side: random ready bursts, plus the long hold-off when asked
  initial begin : color_sink
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // One transaction; entered and left at a falling edge
  task automatic send(input logic k, input logic [15:0] el,
                      input logic [10:0] kx, input logic [10:0] ky);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    elapsed_ms <= el;
    key_x      <= kx;
    key_y      <= ky;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Wait for the block to drain, including ticks still in flight
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic configure(input logic [31:0] period, input logic [31:0] fx,
                           input logic [31:0] fy, input logic [31:0] count,
                           input logic [31:0] ca, input logic [31:0] cb,
                           input logic [31:0] cc, input logic [31:0] cd);
    settle();
    write_reg(CFG_PERIOD, period);
    write_reg(CFG_FREQ_X, fx);
    write_reg(CFG_FREQ_Y, fy);
    write_reg(CFG_COUNT, count);
    write_reg(CFG_COLOR_A, ca);
    write_reg(CFG_COLOR_A + 3'd1, cb);
    write_reg(CFG_COLOR_A + 3'd2, cc);
    write_reg(CFG_COLOR_A + 3'd3, cd);
    cfg_we <= 1'b0;
  endtask

  // Random register value, sometimes with junk above the register width
  function automatic logic [31:0] random_setting(input logic [CFG_IDX_W-1:0] idx);
    logic [31:0] junk, v, mask;
    junk = $urandom_range(0, 1) ? $urandom : 32'h0;
    case (idx)
      CFG_PERIOD: begin
        mask = 32'hFFFF;
        case ($urandom_range(0, 9))
          0:       v = 32'd0;
          1:       v = 32'd1000;
          2:       v = 32'd65535;
          default: v = $urandom_range(1000, 65535);
        endcase
      end
      CFG_FREQ_X, CFG_FREQ_Y: begin
        mask = 32'hFFFF;
        case ($urandom_range(0, 5))
          0:       v = 32'h8000;
          1:       v = 32'h7FFF;
          2:       v = 32'h0;
          default: v = $urandom_range(0, 65535);
        endcase
      end
      CFG_COUNT: begin
        mask = 32'h7;
        v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      end
      default: begin
        mask = 32'hFFFF_FFFF;
        v = $urandom;
      end
    endcase
    return (v & mask) | (junk & ~mask);
  endfunction

  // Key positions: mostly on the layout, some past the edge
  function automatic logic [10:0] random_pos();
    case ($urandom_range(0, 9))
      0:       return 11'd0;
      1:       return 11'd1024;
      2:       return 11'($urandom_range(1025, 2047));
      default: return 11'($urandom_range(0, 1024));
    endcase
  endfunction

  function automatic logic [15:0] random_elapsed();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 300));
    endcase
  endfunction

  initial begin : stimulus
    rst        = 1'b1;
    in_valid   = 1'b0;
    kind       = KIND_TICK;
    elapsed_ms = 16'd0;
    key_x      = 11'd0;
    key_y      = 11'd0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_PERIOD;
    cfg_data   = 32'h0;
    calm       = 1'b0;
    long_hold  = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // defaults: no colors, so a key returns zero
    send(KIND_KEY, 16'h0, 11'd512, 11'd512);
    send(KIND_TICK, 16'h0, 11'd0, 11'd0);

    // four colors, position corners and past-edge saturation
    configure(32'd1000, 32'd4096, 32'd4096, 32'd4,
              32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 32'hFF00_FF00);
    send(KIND_KEY, 16'hFFFF, 11'd0, 11'd0);
    send(KIND_KEY, 16'h0, 11'd1024, 11'd1024);
    send(KIND_KEY, 16'h0, 11'd2047, 11'd2047);
    send(KIND_KEY, 16'h0, 11'd1024, 11'd0);
    send(KIND_KEY, 16'h0, 11'd0, 11'd1024);
    // timer wrap by full modulo
    send(KIND_TICK, 16'hFFFF, 11'd2047, 11'd2047);
    send(KIND_KEY, 16'h0, 11'd300, 11'd700);
    send(KIND_TICK, 16'd999, 11'd0, 11'd0);
    send(KIND_KEY, 16'h0, 11'd0, 11'd0);

    // period change keeps the wave step until the next tick; count above max
    configure(32'hFFFF_FFFF, 32'h0000_8000, 32'h0000_7FFF, 32'hFFFF_FFFF,
              32'hAA55_00FF, 32'h00FF_AA55, 32'h8080_8080, 32'h7F7F_7F7F);
    send(KIND_KEY, 16'h0, 11'd1024, 11'd0);
    send(KIND_KEY, 16'h0, 11'd0, 11'd1024);
    send(KIND_KEY, 16'h0, 11'd1, 11'd2047);
    send(KIND_TICK, 16'hFFFF, 11'd0, 11'd0);
    send(KIND_KEY, 16'h0, 11'd777, 11'd333);

    // zero period clears the timer on a tick
    configure(32'd0, 32'd12345, 32'hFFFF, 32'd3,
              32'h0102_0304, 32'hF0E0_D0C0, 32'h5555_AAAA, 32'h0);
    send(KIND_TICK, 16'd500, 11'd0, 11'd0);
    send(KIND_KEY, 16'h0, 11'd100, 11'd900);
    send(KIND_KEY, 16'h0, 11'd1024, 11'd1024);

    // single color, then two colors
    configure(32'd1000, 32'd0, 32'd0, 32'd1,
              32'hDEAD_BEEF, 32'h0, 32'h0, 32'h0);
    send(KIND_KEY, 16'h0, 11'd0, 11'd0);
    send(KIND_TICK, 16'd1, 11'd0, 11'd0);
    send(KIND_KEY, 16'h0, 11'd5, 11'd5);
    configure(32'd1000, 32'd2048, 32'd1024, 32'd2,
              32'hFF00_0000, 32'h00FF_FF00, 32'h0, 32'h0);
    send(KIND_KEY, 16'h0, 11'd0, 11'd0);
    send(KIND_KEY, 16'h0, 11'd512, 11'd256);

    // random phases, the last one without idling
    for (int p = 0; p < PHASES; p++) begin
      configure(random_setting(CFG_PERIOD), random_setting(CFG_FREQ_X),
                random_setting(CFG_FREQ_Y), random_setting(CFG_COUNT),
                random_setting(CFG_COLOR_A), random_setting(CFG_COLOR_A + 3'd1),
                random_setting(CFG_COLOR_A + 3'd2), random_setting(CFG_COLOR_A + 3'd3));
      if (p == PHASES - 1) calm = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == 20) long_hold = 1'b1;
        if ($urandom_range(0, 99) < 65)
          send(KIND_KEY, 16'($urandom), random_pos(), random_pos());
        else
          send(KIND_TICK, random_elapsed(), 11'($urandom), 11'($urandom));
      end
    end

    settle();
    if (fail_count == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
